FILE: rtl/core/cmbe_pkg.sv
// ----------------------------------------------------------------------------
// cmbe_pkg
// Types and constants shared by the combination enumerator modules.
// ----------------------------------------------------------------------------
package cmbe_pkg;

    localparam int SET_W      = 6;
    localparam int PICK_W     = 5;
    localparam int POS_W      = 4;
    localparam int SLOT_COUNT = 16;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int TOP_W      = SET_W + 1;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_SET_SIZE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PICK_COUNT = 1'd1;

    localparam logic [SET_W-1:0]  SET_SIZE_RESET   = 6'd5;
    localparam logic [PICK_W-1:0] PICK_COUNT_RESET = 5'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_EMIT
    } cmbe_state_t;

    typedef struct packed {
        logic capture;
        logic load_init;
        logic load_step;
        logic set_finished;
        logic emit_exh;
        logic emit_elem;
    } dp_cmd_t;

    typedef struct packed {
        logic valid;
        logic init;
        logic finished;
        logic found;
        logic last_pos;
    } dp_status_t;

endpackage

FILE: rtl/core/cmbe_ctrl.sv
// ----------------------------------------------------------------------------
// cmbe_ctrl
// Sequencer: evaluates a request, then steps the datapath through the items.
// ----------------------------------------------------------------------------
module cmbe_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  cmbe_pkg::dp_status_t  status,
    output cmbe_pkg::dp_cmd_t     cmd
);
    import cmbe_pkg::*;

    cmbe_state_t state_reg;
    cmbe_state_t state_next;
    logic        give_exh;

    assign give_exh = !status.valid || (!status.init && (status.finished || !status.found));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = give_exh ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.last_pos)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy        = 1'b0;
                cmd.capture = start;
            end
            ST_EVAL:
            begin
                cmd.emit_exh     = give_exh;
                cmd.set_finished = status.valid && !status.init && !status.finished
                                   && !status.found;
                cmd.load_init    = status.valid && status.init;
                cmd.load_step    = status.valid && !status.init && !status.finished
                                   && status.found;
            end
            ST_EMIT:
            begin
                cmd.emit_elem = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

FILE: rtl/core/cmbe_datapath.sv
// ----------------------------------------------------------------------------
// cmbe_datapath
// Registers, current combination, pivot search and item output registers.
// ----------------------------------------------------------------------------
module cmbe_datapath #(
    parameter int MAX_SET  = 32,
    parameter int MAX_PICK = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 restart,
    input  logic                                 wr_en,
    input  logic [cmbe_pkg::CFG_IDX_W-1:0]       wr_index,
    input  logic [cmbe_pkg::SET_W-1:0]           wr_data,
    input  cmbe_pkg::dp_cmd_t                    cmd,
    output cmbe_pkg::dp_status_t                 status,
    output logic                                 strobe,
    output logic [cmbe_pkg::SET_W-1:0]           element_value,
    output logic [cmbe_pkg::POS_W-1:0]           position,
    output logic                                 last_of_combination,
    output logic                                 final_combination,
    output logic                                 exhausted
);
    import cmbe_pkg::*;

    logic [SET_W-1:0]  set_size_reg;
    logic [PICK_W-1:0] pick_count_reg;
    logic              started_reg;
    logic              finished_reg;
    logic              restart_reg;
    logic [SET_W-1:0]  chosen_reg [SLOT_COUNT];
    logic [SLOT_W-1:0] pivot_reg;
    logic [SLOT_W-1:0] pos_reg;
    logic [SET_W-1:0]  first_reg;
    logic [SET_W-1:0]  prev_reg;
    logic              final_reg;

    logic              strobe_reg;
    logic [SET_W-1:0]  value_reg;
    logic [POS_W-1:0]  position_reg;
    logic              last_reg;
    logic              fin_out_reg;
    logic              exh_reg;

    logic [TOP_W-1:0]  top;
    logic              regs_ok;
    logic              found;
    logic [SLOT_W-1:0] found_idx;
    logic [SET_W-1:0]  c0_next;
    logic [SET_W-1:0]  elem_next;
    logic              last_pos;

    assign top = {1'b0, set_size_reg} - TOP_W'(pick_count_reg) + TOP_W'(1);

    assign regs_ok = (set_size_reg != '0) && (pick_count_reg != '0)
                     && (set_size_reg >= SET_W'(pick_count_reg))
                     && (32'(set_size_reg) <= 32'(MAX_SET))
                     && (32'(pick_count_reg) <= 32'(MAX_PICK))
                     && (32'(pick_count_reg) <= 32'(SLOT_COUNT));

    // rightmost slot that can still rise
    always_comb
    begin
        found     = 1'b0;
        found_idx = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if ((PICK_W'(i) < pick_count_reg)
                && ({1'b0, chosen_reg[i]} < (top + TOP_W'(i))))
            begin
                found     = 1'b1;
                found_idx = SLOT_W'(i);
            end
        end
    end

    assign c0_next = (found_idx == '0) ? chosen_reg[0] + SET_W'(1) : chosen_reg[0];

    assign last_pos = ({1'b0, pos_reg} == (pick_count_reg - PICK_W'(1)));

    always_comb
    begin
        if (pos_reg < pivot_reg)
        begin
            elem_next = chosen_reg[pos_reg];
        end
        else if (pos_reg == pivot_reg)
        begin
            elem_next = first_reg;
        end
        else
        begin
            elem_next = prev_reg + SET_W'(1);
        end
    end

    assign status.valid    = regs_ok;
    assign status.init     = restart_reg || !started_reg;
    assign status.finished = finished_reg;
    assign status.found    = found;
    assign status.last_pos = last_pos;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_size_reg   <= SET_SIZE_RESET;
            pick_count_reg <= PICK_COUNT_RESET;
            started_reg    <= 1'b0;
            finished_reg   <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.emit_exh || cmd.emit_elem;
            if (wr_en)
            begin
                if (wr_index == REG_SET_SIZE)
                begin
                    set_size_reg <= wr_data;
                end
                else
                begin
                    pick_count_reg <= wr_data[PICK_W-1:0];
                end
                started_reg  <= 1'b0;
                finished_reg <= 1'b0;
            end
            else if (cmd.load_init)
            begin
                started_reg  <= 1'b1;
                finished_reg <= 1'b0;
            end
            else if (cmd.set_finished)
            begin
                finished_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            restart_reg <= restart;
        end

        if (cmd.load_init)
        begin
            pivot_reg <= '0;
            first_reg <= SET_W'(1);
            final_reg <= (top == TOP_W'(1));
            pos_reg   <= '0;
        end
        else if (cmd.load_step)
        begin
            pivot_reg <= found_idx;
            first_reg <= chosen_reg[found_idx] + SET_W'(1);
            final_reg <= ({1'b0, c0_next} == top);
            pos_reg   <= '0;
        end
        else if (cmd.emit_elem)
        begin
            pos_reg <= pos_reg + SLOT_W'(1);
        end

        if (cmd.emit_elem)
        begin
            chosen_reg[pos_reg] <= elem_next;
            prev_reg            <= elem_next;
            value_reg           <= elem_next;
            position_reg        <= POS_W'(pos_reg);
            last_reg            <= last_pos;
            fin_out_reg         <= final_reg;
            exh_reg             <= 1'b0;
        end
        else if (cmd.emit_exh)
        begin
            value_reg    <= '0;
            position_reg <= '0;
            last_reg     <= 1'b1;
            fin_out_reg  <= 1'b0;
            exh_reg      <= 1'b1;
        end
    end

    assign strobe              = strobe_reg;
    assign element_value       = value_reg;
    assign position            = position_reg;
    assign last_of_combination = last_reg;
    assign final_combination   = fin_out_reg;
    assign exhausted           = exh_reg;

endmodule

FILE: rtl/core/combination_enumerator_top.sv
// ----------------------------------------------------------------------------
// combination_enumerator_top
// Lexicographic k-of-n combination generator, one element per item.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The sequencer then
// runs the pivot search in its EVAL state; a valid combination then leaves
// as k items, one per cycle, each on the output ports for a single cycle with
// strobe high, driven from output registers loaded in the EMIT state. busy
// stays high through EVAL and EMIT (EVAL alone for an exhausted item). The
// receiver cannot stall; items must be taken as they come. The user must
// write registers only while busy is low; the block does not enforce this.
// ----------------------------------------------------------------------------
module combination_enumerator_top #(
    parameter int MAX_SET  = 32,
    parameter int MAX_PICK = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             restart,
    input  logic                             wr_en,
    input  logic [cmbe_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [cmbe_pkg::SET_W-1:0]       wr_data,
    output logic                             strobe,
    output logic [cmbe_pkg::SET_W-1:0]       element_value,
    output logic [cmbe_pkg::POS_W-1:0]       position,
    output logic                             last_of_combination,
    output logic                             final_combination,
    output logic                             exhausted
);
    import cmbe_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    cmbe_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    cmbe_datapath #(
        .MAX_SET  (MAX_SET),
        .MAX_PICK (MAX_PICK)
    ) u_datapath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .restart             (restart),
        .wr_en               (wr_en),
        .wr_index            (wr_index),
        .wr_data             (wr_data),
        .cmd                 (cmd),
        .status              (status),
        .strobe              (strobe),
        .element_value       (element_value),
        .position            (position),
        .last_of_combination (last_of_combination),
        .final_combination   (final_combination),
        .exhausted           (exhausted)
    );

endmodule
